>>> hdl/qslerp_pkg.sv
// Shared constants, coefficient tables and pipeline bus types for the quaternion slerp core.
package qslerp_pkg;

  // Number of Horner terms, held to the table depth
  localparam int TERM_COUNT = 8;
  localparam int TERMS = (TERM_COUNT > 8) ? 8 : ((TERM_COUNT < 1) ? 1 : TERM_COUNT);

  // Coefficient tables, Q30
  localparam logic [29:0] TAB_U [8] = '{
    30'd357913941, 30'd107374182, 30'd51130563, 30'd29826162,
    30'd19522579,  30'd13765921,  30'd10226113, 30'd15009548
  };
  localparam logic [29:0] TAB_V [8] = '{
    30'd357913941, 30'd429496730, 30'd460175067, 30'd477218588,
    30'd488064465, 30'd495573150, 30'd501079518, 30'd960611099
  };

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [16:0] Q16_ONE = 17'h1_0000;

  // Item payload carried alongside the weight computation
  typedef struct packed {
    logic [3:0][15:0] a;     // first quaternion, index 0 is x
    logic [3:0][15:0] b;     // second quaternion
    logic [16:0]      t;     // clamped blend, Q16
    logic [16:0]      omt;   // 1 - t, Q16
    logic             flip;  // dot was negative
  } side_t;

  // Bus handed from cell to cell along the Horner chain
  typedef struct packed {
    logic        valid;
    logic [16:0] sq_t;   // t*t, Q16
    logic [16:0] sq_o;   // (1-t)^2, Q16
    logic [16:0] dmm;    // 1 - |dot|, Q16 magnitude
    logic [30:0] acc_a;  // Horner accumulator for the A weight, Q30
    logic [30:0] acc_b;  // Horner accumulator for the B weight, Q30
    side_t       side;
  } bus_t;

endpackage

>>> hdl/quaternion_slerp_approx_core.sv
// Top level of the fixed-point approximate quaternion slerp core.
//
// Takes one quaternion pair and blend factor per clock: an item transfers on
// any clock edge with start high, and busy is never raised. Each result appears
// for exactly one cycle with done high, in the order the items came in. The
// pipeline is the row of Horner cells, three register stages per term, between
// a three-stage dot product front end and a four-stage weighting back end.
// Results cannot be held off; the receiver must take them as they come.
module quaternion_slerp_approx_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] a_x,
  input  logic signed [15:0] a_y,
  input  logic signed [15:0] a_z,
  input  logic signed [15:0] a_w,
  input  logic signed [15:0] b_x,
  input  logic signed [15:0] b_y,
  input  logic signed [15:0] b_z,
  input  logic signed [15:0] b_w,
  input  logic [16:0]        blend,
  output logic               done,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic signed [15:0] out_w
);

  qslerp_pkg::bus_t chain [qslerp_pkg::TERMS + 1];

  // Fully pipelined: never stalls the sender
  assign busy = 1'b0;

  qslerp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .a_x     (a_x),
    .a_y     (a_y),
    .a_z     (a_z),
    .a_w     (a_w),
    .b_x     (b_x),
    .b_y     (b_y),
    .b_z     (b_z),
    .b_w     (b_w),
    .blend   (blend),
    .bus_out (chain[0])
  );

  // Horner row: first cell takes the highest term, last cell term zero
  for (genvar k = 0; k < qslerp_pkg::TERMS; k++) begin : g_cell
    qslerp_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .u       (qslerp_pkg::TAB_U[qslerp_pkg::TERMS - 1 - k]),
      .v       (qslerp_pkg::TAB_V[qslerp_pkg::TERMS - 1 - k]),
      .bus_in  (chain[k]),
      .bus_out (chain[k + 1])
    );
  end

  qslerp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .bus_in (chain[qslerp_pkg::TERMS]),
    .done   (done),
    .out_x  (out_x),
    .out_y  (out_y),
    .out_z  (out_z),
    .out_w  (out_w)
  );

endmodule

>>> hdl/qslerp_front.sv
// Front end: dot product, blend clamp, squares and start of the Horner bus.
module qslerp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [15:0]  a_x,
  input  logic signed [15:0]  a_y,
  input  logic signed [15:0]  a_z,
  input  logic signed [15:0]  a_w,
  input  logic signed [15:0]  b_x,
  input  logic signed [15:0]  b_y,
  input  logic signed [15:0]  b_z,
  input  logic signed [15:0]  b_w,
  input  logic [16:0]         blend,
  output qslerp_pkg::bus_t    bus_out
);

  logic [16:0]        t_cl;
  logic [16:0]        omt_cl;

  logic               vld1;
  logic signed [31:0] prod1 [4];
  logic [32:0]        tt1;
  logic [32:0]        oo1;
  qslerp_pkg::side_t  side1;

  logic               vld2;
  logic signed [33:0] dot2;
  logic [16:0]        sq_t2;
  logic [16:0]        sq_o2;
  qslerp_pkg::side_t  side2;

  logic [32:0]        dmag_abs;
  logic [32:0]        dmag_rnd;
  logic [20:0]        dmag_sh;
  logic [16:0]        dmag;
  logic               flip;
  logic [32:0]        tt_rnd;
  logic [32:0]        oo_rnd;

  qslerp_pkg::bus_t   bus3;
  logic               vld3;

  // Blend saturates at one
  always_comb begin
    t_cl   = (blend > qslerp_pkg::Q16_ONE) ? qslerp_pkg::Q16_ONE : blend;
    omt_cl = qslerp_pkg::Q16_ONE - t_cl;
  end

  // Stage 1: component products and squares
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= start;
    end
  end

  always_ff @(posedge clk) begin
    prod1[0]   <= a_x * b_x;
    prod1[1]   <= a_y * b_y;
    prod1[2]   <= a_z * b_z;
    prod1[3]   <= a_w * b_w;
    tt1        <= 33'(t_cl) * 33'(t_cl);
    oo1        <= 33'(omt_cl) * 33'(omt_cl);
    side1.a    <= {a_w, a_z, a_y, a_x};
    side1.b    <= {b_w, b_z, b_y, b_x};
    side1.t    <= t_cl;
    side1.omt  <= omt_cl;
    side1.flip <= 1'b0;
  end

  // Stage 2: dot sum and rounded squares
  always_comb begin
    tt_rnd = tt1 + 33'd32768;
    oo_rnd = oo1 + 33'd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    dot2  <= 34'(prod1[0]) + 34'(prod1[1]) + 34'(prod1[2]) + 34'(prod1[3]);
    sq_t2 <= tt_rnd[32:16];
    sq_o2 <= oo_rnd[32:16];
    side2 <= side1;
  end

  // Stage 3: magnitude of the dot, rounded to Q16 and clamped to one
  always_comb begin
    flip     = dot2[33];
    dmag_abs = flip ? 33'(-dot2) : 33'(dot2);
    dmag_rnd = dmag_abs + 33'd2048;
    dmag_sh  = dmag_rnd[32:12];
    dmag     = (dmag_sh > 21'(qslerp_pkg::Q16_ONE)) ? qslerp_pkg::Q16_ONE : dmag_sh[16:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    bus3.valid     <= vld2;
    bus3.sq_t      <= sq_t2;
    bus3.sq_o      <= sq_o2;
    bus3.dmm       <= qslerp_pkg::Q16_ONE - dmag;
    bus3.acc_a     <= qslerp_pkg::Q30_ONE;
    bus3.acc_b     <= qslerp_pkg::Q30_ONE;
    bus3.side.a    <= side2.a;
    bus3.side.b    <= side2.b;
    bus3.side.t    <= side2.t;
    bus3.side.omt  <= side2.omt;
    bus3.side.flip <= flip;
  end

  always_comb begin
    bus_out       = bus3;
    bus_out.valid = vld3;
  end

endmodule

>>> hdl/qslerp_cell.sv
// Horner cell: one coefficient term for both weights, three register stages.
module qslerp_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic [29:0]      u,
  input  logic [29:0]      v,
  input  qslerp_pkg::bus_t bus_in,
  output qslerp_pkg::bus_t bus_out
);

  logic             vld1, vld2, vld3;
  qslerp_pkg::bus_t bus1, bus2, bus3;

  logic [46:0] pt1, po1;
  logic [46:0] pt_rnd, po_rnd;
  logic [29:0] et, eo;

  logic [46:0] qt2, qo2;
  logic [46:0] qt_rnd, qo_rnd;
  logic [29:0] bt, bo;

  logic [60:0] rt3, ro3;
  logic [60:0] rt_rnd, ro_rnd;

  // Valid tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      vld1 <= bus_in.valid;
      vld2 <= vld1;
      vld3 <= vld2;
    end
  end

  // Stage 1: U times square
  always_ff @(posedge clk) begin
    bus1 <= bus_in;
    pt1  <= 47'(u) * 47'(bus_in.sq_t);
    po1  <= 47'(u) * 47'(bus_in.sq_o);
  end

  // |e| = V - round(U*sq); never negative as U <= V
  always_comb begin
    pt_rnd = pt1 + 47'd32768;
    po_rnd = po1 + 47'd32768;
    et     = v - pt_rnd[45:16];
    eo     = v - po_rnd[45:16];
  end

  // Stage 2: term times (1 - |dot|)
  always_ff @(posedge clk) begin
    bus2 <= bus1;
    qt2  <= 47'(et) * 47'(bus1.dmm);
    qo2  <= 47'(eo) * 47'(bus1.dmm);
  end

  always_comb begin
    qt_rnd = qt2 + 47'd32768;
    qo_rnd = qo2 + 47'd32768;
    bt     = qt_rnd[45:16];
    bo     = qo_rnd[45:16];
  end

  // Stage 3: term times running accumulator
  always_ff @(posedge clk) begin
    bus3 <= bus2;
    rt3  <= 61'(bt) * 61'(bus2.acc_b);
    ro3  <= 61'(bo) * 61'(bus2.acc_a);
  end

  // New accumulator: 1 + round(b * acc)
  always_comb begin
    rt_rnd        = rt3 + 61'h2000_0000;
    ro_rnd        = ro3 + 61'h2000_0000;
    bus_out       = bus3;
    bus_out.valid = vld3;
    bus_out.acc_b = qslerp_pkg::Q30_ONE + rt_rnd[60:30];
    bus_out.acc_a = qslerp_pkg::Q30_ONE + ro_rnd[60:30];
  end

endmodule

>>> hdl/qslerp_back.sv
// Back end: weight scaling, weighted sum of the quaternions, rounding and saturation.
module qslerp_back (
  input  logic               clk,
  input  logic               rst,
  input  qslerp_pkg::bus_t   bus_in,
  output logic               done,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic signed [15:0] out_w
);

  logic               vld1, vld2, vld3;
  logic [47:0]        pa1, pb1;
  qslerp_pkg::side_t  side1, side2;

  logic [47:0]        pa_rnd, pb_rnd;
  logic signed [32:0] wa2, wb2;
  logic signed [32:0] wb_mag;

  logic signed [48:0] ma3 [4];
  logic signed [48:0] mb3 [4];

  logic signed [49:0] sum  [4];
  logic [49:0]        mag  [4];
  logic [49:0]        mrnd [4];
  logic [19:0]        rq   [4];
  logic [15:0]        res  [4];
  logic [15:0]        ores [4];

  // Valid tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      done <= 1'b0;
    end else begin
      vld1 <= bus_in.valid;
      vld2 <= vld1;
      vld3 <= vld2;
      done <= vld3;
    end
  end

  // Stage 1: scale accumulators by 1-t and t
  always_ff @(posedge clk) begin
    pa1   <= 48'(bus_in.side.omt) * 48'(bus_in.acc_a);
    pb1   <= 48'(bus_in.side.t) * 48'(bus_in.acc_b);
    side1 <= bus_in.side;
  end

  // Stage 2: rounded weights, B weight negated on a negative dot
  always_comb begin
    pa_rnd = pa1 + 48'd32768;
    pb_rnd = pb1 + 48'd32768;
    wb_mag = {1'b0, pb_rnd[47:16]};
  end

  always_ff @(posedge clk) begin
    wa2   <= {1'b0, pa_rnd[47:16]};
    wb2   <= side1.flip ? -wb_mag : wb_mag;
    side2 <= side1;
  end

  // Stage 3: per-component products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      ma3[k] <= wa2 * $signed(side2.a[k]);
      mb3[k] <= wb2 * $signed(side2.b[k]);
    end
  end

  // Sum, round half away from zero to Q14, saturate
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k]  = 50'(ma3[k]) + 50'(mb3[k]);
      mag[k]  = sum[k][49] ? 50'(-sum[k]) : 50'(sum[k]);
      mrnd[k] = mag[k] + 50'h2000_0000;
      rq[k]   = mrnd[k][49:30];
      if (sum[k][49]) begin
        res[k] = (rq[k] > 20'd32768) ? 16'h8000 : 16'(-rq[k][15:0]);
      end else begin
        res[k] = (rq[k] > 20'd32767) ? 16'h7fff : rq[k][15:0];
      end
    end
  end

  // Stage 4: result registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      ores[k] <= res[k];
    end
  end

  assign out_x = $signed(ores[0]);
  assign out_y = $signed(ores[1]);
  assign out_z = $signed(ores[2]);
  assign out_w = $signed(ores[3]);

endmodule

>>> sim/quaternion_slerp_approx_core_tb.sv
// Self-checking testbench for the fixed-point quaternion slerp core.
module quaternion_slerp_approx_core_tb;

  // Pipeline depth of the core, used for the final settle time
  localparam int PIPE_DEPTH  = 3 + 3 * qslerp_pkg::TERMS + 4;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_PAIRS = 1600;

  localparam longint ONE16 = 64'sd65536;
  localparam longint ONE30 = 64'sd1073741824;

  // Series coefficient tables, Q30
  localparam longint COEF_U [8] = '{
    64'sd357913941, 64'sd107374182, 64'sd51130563, 64'sd29826162,
    64'sd19522579,  64'sd13765921,  64'sd10226113, 64'sd15009548
  };
  localparam longint COEF_V [8] = '{
    64'sd357913941, 64'sd429496730, 64'sd460175067, 64'sd477218588,
    64'sd488064465, 64'sd495573150, 64'sd501079518, 64'sd960611099
  };

  localparam string AXES = "xyzw";

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] w;
  } quat_t;

  typedef struct packed {
    quat_t       a;
    quat_t       b;
    logic [16:0] blend;
  } pair_t;

  typedef struct {
    pair_t p;
    bit    known;   // result typed in below rather than predicted
    quat_t want;
  } vector_t;

  localparam quat_t ZERO_Q    = '{0, 0, 0, 0};
  localparam quat_t IDENT     = '{0, 0, 0, 16384};
  localparam quat_t NEG_IDENT = '{0, 0, 0, -16384};
  localparam quat_t MIN_Q     = '{-32768, -32768, -32768, -32768};
  localparam quat_t MAX_Q     = '{32767, 32767, 32767, 32767};

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [15:0] a_x, a_y, a_z, a_w;
  logic signed [15:0] b_x, b_y, b_z, b_w;
  logic [16:0]        blend;
  logic               done;
  logic signed [15:0] out_x, out_y, out_z, out_w;

  quat_t expected_q [$];
  int    cycle_count = 0;
  int    mismatches = 0;
  int    pairs_sent = 0;
  int    results_seen = 0;
  int    flipped_pairs = 0;
  int    saturated_comps = 0;

  quaternion_slerp_approx_core i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .a_x   (a_x),
    .a_y   (a_y),
    .a_z   (a_z),
    .a_w   (a_w),
    .b_x   (b_x),
    .b_y   (b_y),
    .b_z   (b_z),
    .b_w   (b_w),
    .blend (blend),
    .done  (done),
    .out_x (out_x),
    .out_y (out_y),
    .out_z (out_z),
    .out_w (out_w)
  );

  always #5 clk = ~clk;

  // Right shift rounding half away from zero
  function automatic longint round_shift(input longint v, input int s);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Nested series factor 1 + b0*(1 + b1*(...)), Q30
  function automatic longint series_factor(input longint sq, input longint dm1);
    longint acc, e, term;
    acc = ONE30;
    for (int i = qslerp_pkg::TERMS - 1; i >= 0; i--) begin
      e    = round_shift(COEF_U[i] * sq, 16) - COEF_V[i];
      term = round_shift(e * dm1, 16);
      acc  = ONE30 + round_shift(term * acc, 30);
    end
    return acc;
  endfunction

  function automatic logic signed [15:0] saturate16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Interpolated quaternion for one pair; flipped reports a negative dot
  function automatic quat_t slerp_predict(input pair_t p, output bit flipped);
    longint av [4];
    longint bv [4];
    longint dot, dmag, dm1, t, omt, w_a, w_b;
    logic signed [15:0] res [4];
    quat_t r;
    av = '{longint'(p.a.x), longint'(p.a.y), longint'(p.a.z), longint'(p.a.w)};
    bv = '{longint'(p.b.x), longint'(p.b.y), longint'(p.b.z), longint'(p.b.w)};
    dot = 0;
    for (int k = 0; k < 4; k++) dot += av[k] * bv[k];
    // t saturates at one
    t = longint'(p.blend);
    if (t > ONE16) t = ONE16;
    omt = ONE16 - t;
    // negative dot: take the magnitude, negate the B weight
    flipped = dot < 0;
    if (flipped) dot = -dot;
    dmag = round_shift(dot, 12);
    if (dmag > ONE16) dmag = ONE16;
    dm1 = dmag - ONE16;
    w_b = round_shift(t * series_factor(round_shift(t * t, 16), dm1), 16);
    if (flipped) w_b = -w_b;
    w_a = round_shift(omt * series_factor(round_shift(omt * omt, 16), dm1), 16);
    for (int k = 0; k < 4; k++)
      res[k] = saturate16(round_shift(w_a * av[k] + w_b * bv[k], 30));
    r.x = res[0];
    r.y = res[1];
    r.z = res[2];
    r.w = res[3];
    return r;
  endfunction

  // Present one pair after an idle gap and hold it until it transfers
  task automatic send_pair(input pair_t p, input int gap, input bit known, input quat_t want);
    quat_t predicted;
    bit    flipped;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    a_x   <= p.a.x;
    a_y   <= p.a.y;
    a_z   <= p.a.z;
    a_w   <= p.a.w;
    b_x   <= p.b.x;
    b_y   <= p.b.y;
    b_z   <= p.b.z;
    b_w   <= p.b.w;
    blend <= p.blend;
    do @(posedge clk); while (busy);
    predicted = slerp_predict(p, flipped);
    expected_q.push_back(known ? want : predicted);
    pairs_sent++;
    if (flipped) flipped_pairs++;
  endtask

  // Stop sending until every outstanding result has come back
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  function automatic logic signed [15:0] unit_comp();
    return 16'($signed($urandom_range(0, 16384)) - 8192);
  endfunction

  function automatic logic signed [15:0] edge_comp();
    case ($urandom_range(0, 5))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return -16'sd1;
      4: return 16'sd16384;
      default: return -16'sd16384;
    endcase
  endfunction

  // Random pair: mostly unit-ball quaternions so the series is exercised
  function automatic pair_t draw_pair();
    pair_t p;
    int    kind;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      p.a = '{unit_comp(), unit_comp(), unit_comp(), unit_comp()};
      p.b = '{unit_comp(), unit_comp(), unit_comp(), unit_comp()};
    end else if (kind < 70) begin
      // nearly parallel, half of them on the opposite hemisphere
      p.a = '{unit_comp(), unit_comp(), unit_comp(), unit_comp()};
      p.b.x = p.a.x + 16'($signed($urandom_range(0, 512)) - 256);
      p.b.y = p.a.y + 16'($signed($urandom_range(0, 512)) - 256);
      p.b.z = p.a.z + 16'($signed($urandom_range(0, 512)) - 256);
      p.b.w = p.a.w + 16'($signed($urandom_range(0, 512)) - 256);
      if ($urandom_range(0, 1)) p.b = '{-p.b.x, -p.b.y, -p.b.z, -p.b.w};
    end else if (kind < 85) begin
      p.a = {$urandom, $urandom};
      p.b = {$urandom, $urandom};
    end else begin
      p.a = '{edge_comp(), edge_comp(), edge_comp(), edge_comp()};
      p.b = '{edge_comp(), edge_comp(), edge_comp(), edge_comp()};
    end
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      p.blend = 17'($urandom_range(0, 65536));
    end else if (kind < 85) begin
      case ($urandom_range(0, 3))
        0: p.blend = 17'd0;
        1: p.blend = 17'd1;
        2: p.blend = 17'd65535;
        default: p.blend = 17'd65536;
      endcase
    end else begin
      p.blend = 17'($urandom_range(65537, 131071));
    end
    return p;
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  // Result check, one transfer per done cycle
  always @(posedge clk) begin : result_check
    quat_t want;
    logic signed [15:0] got_c [4];
    logic signed [15:0] want_c [4];
    if (rst === 1'b0 && done === 1'b1) begin
      if (expected_q.size() == 0) begin
        note_mismatch($sformatf("result with nothing outstanding: %0d %0d %0d %0d",
                                out_x, out_y, out_z, out_w));
      end else begin
        want   = expected_q.pop_front();
        got_c  = '{out_x, out_y, out_z, out_w};
        want_c = '{want.x, want.y, want.z, want.w};
        for (int k = 0; k < 4; k++) begin
          if (got_c[k] !== want_c[k])
            note_mismatch($sformatf("out_%c on result %0d: expected %0d, got %0d",
                                    AXES[k], results_seen, want_c[k], got_c[k]));
          if (got_c[k] == 16'sh7fff || got_c[k] == 16'sh8000) saturated_comps++;
        end
      end
      results_seen++;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    vector_t directed_rows [$];
    int      gap;
    bit      burst;
    rst   = 1'b1;
    start = 1'b0;
    a_x   = '0;
    a_y   = '0;
    a_z   = '0;
    a_w   = '0;
    b_x   = '0;
    b_y   = '0;
    b_z   = '0;
    b_w   = '0;
    blend = '0;

    // Directed pairs: extremes, identity and opposite, dot zero, blend above one
    directed_rows = '{
      '{'{ZERO_Q, ZERO_Q, 17'd0},          1'b1, ZERO_Q},
      '{'{ZERO_Q, ZERO_Q, 17'd131071},     1'b1, ZERO_Q},
      '{'{IDENT, IDENT, 17'd0},            1'b1, IDENT},
      '{'{IDENT, IDENT, 17'd32768},        1'b1, IDENT},
      '{'{IDENT, IDENT, 17'd65536},        1'b1, IDENT},
      '{'{IDENT, IDENT, 17'd131071},       1'b1, IDENT},
      '{'{IDENT, NEG_IDENT, 17'd0},        1'b1, IDENT},
      '{'{IDENT, NEG_IDENT, 17'd65536},    1'b1, IDENT},
      '{'{MIN_Q, MIN_Q, 17'd0},            1'b1, MIN_Q},
      '{'{MIN_Q, MIN_Q, 17'd65536},        1'b1, MIN_Q},
      '{'{'{16384, 0, 0, 0}, '{0, 16384, 0, 0}, 17'd32768}, 1'b0, ZERO_Q},
      '{'{MAX_Q, '{32767, -32767, 32767, -32767}, 17'd32768}, 1'b0, ZERO_Q},
      '{'{'{16384, 0, 0, 0}, '{-1, 16384, 0, 0}, 17'd16384}, 1'b0, ZERO_Q},
      '{'{'{32767, -32768, 32767, -32768}, '{-32768, 32767, -32768, 32767}, 17'd1},
        1'b0, ZERO_Q},
      '{'{IDENT, '{0, 0, 11585, 11585}, 17'd49152}, 1'b0, ZERO_Q},
      '{'{'{-32768, 0, 0, 0}, '{32767, 0, 0, 0}, 17'd65535}, 1'b0, ZERO_Q},
      '{'{'{5000, -7000, 3000, 12000}, '{-6000, 2000, 9000, -1000}, 17'd65537},
        1'b0, ZERO_Q}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_pair(directed_rows[i].p, $urandom_range(0, 16),
                directed_rows[i].known, directed_rows[i].want);
    wait_for_results();

    // Random pairs, with bursts of back-to-back transfers and the odd full drain
    burst = 1'b0;
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_PAIRS / 2 || $urandom_range(0, 299) == 0) wait_for_results();
      gap = burst ? 0 : $urandom_range(0, 16);
      send_pair(draw_pair(), gap, 1'b0, ZERO_Q);
    end

    // Let the pipeline empty, then settle
    wait_for_results();
    repeat (PIPE_DEPTH + 8) @(posedge clk);

    $display("%0d pairs transferred, %0d results compared, %0d cycles",
             pairs_sent, results_seen, cycle_count);
    $display("%0d pairs with negative dot, %0d output components at the 16-bit limits",
             flipped_pairs, saturated_comps);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, expected_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
